### rtl/edge_list_tsv_parser_macros.svh
// ----------------------------------------------------------------------------
// Edge-list TSV parser assertion macros
// Concurrent assertion forms used by the parser emitter.
// ----------------------------------------------------------------------------
`ifndef EDGE_LIST_TSV_PARSER_MACROS_SVH
`define EDGE_LIST_TSV_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ETP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ETP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/etp_pkg.sv
// ----------------------------------------------------------------------------
// Edge-list TSV parser package
// Types and constants shared by the parser front end, queue and emitter.
// ----------------------------------------------------------------------------
package etp_pkg;

    localparam int ACC_W       = 34;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [3:0] MAX_DIGITS = 4'd10;
    localparam logic [3:0] TALLY_SAT  = 4'd11;

    typedef enum logic [2:0] {
        PH_LINE   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_TAB1   = 3'd2,
        PH_SECOND = 3'd3,
        PH_TAB2   = 3'd4,
        PH_WEIGHT = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_EDGE     = 3'd0,
        ST_DIGIT    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_TAB      = 3'd3,
        ST_TRAIL    = 3'd4,
        ST_NO_EDGES = 3'd5,
        ST_DONE     = 3'd6
    } status_t;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic [7:0]  weight;
        status_t     status;
        logic        is_end;
        logic        has_pre;
    } entry_t;

endpackage

### rtl/etp_front.sv
// ----------------------------------------------------------------------------
// Edge-list TSV parser front end
// Classifies each byte, tracks line phase and number accumulation, and
// queues one record per byte that produces results.
// ----------------------------------------------------------------------------
module etp_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            stream_end,
    output logic            push,
    output etp_pkg::entry_t push_entry
);
    import etp_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [3:0]          tally_reg, tally_next;
    logic [31:0]         held_first_reg, held_first_next;
    logic [31:0]         held_second_reg, held_second_next;
    logic                any_edge_reg, any_edge_next;
    logic                err_reg, err_next;

    logic                is_digit;
    logic                is_eol;
    logic                is_tab;
    logic [3:0]          digit_val;
    logic [ACC_W-1:0]    acc_x10;
    logic                node_oor;
    logic                weight_oor;

    assign is_digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign is_eol     = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);
    assign is_tab     = (data_byte == CHAR_TAB);
    assign digit_val  = data_byte[3:0];
    assign acc_x10    = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0}
                        + {{(ACC_W-4){1'b0}}, digit_val};
    assign node_oor   = (tally_reg > MAX_DIGITS) || (acc_reg[ACC_W-1:32] != '0);
    assign weight_oor = (tally_reg > MAX_DIGITS) || (acc_reg[ACC_W-1:8] != '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (stream_end)
            begin
                phase_next = PH_LINE;
            end
            else if (!err_reg)
            begin
                unique case (phase_reg)
                    PH_LINE:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_FIRST:
                    begin
                        if (!is_digit && !node_oor && is_tab)
                        begin
                            phase_next = PH_TAB1;
                        end
                    end
                    PH_SECOND:
                    begin
                        if (!is_digit && !node_oor && is_tab)
                        begin
                            phase_next = PH_TAB2;
                        end
                    end
                    PH_TAB1:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_SECOND;
                        end
                    end
                    PH_TAB2:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_WEIGHT;
                        end
                    end
                    default:
                    begin
                        if (!is_digit && !weight_oor && is_eol)
                        begin
                            phase_next = PH_LINE;
                        end
                    end
                endcase
            end
        end
    end

    // datapath and queued record
    always_comb
    begin
        acc_next         = acc_reg;
        tally_next       = tally_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        any_edge_next    = any_edge_reg;
        err_next         = err_reg;
        push             = 1'b0;
        push_entry       = '{first: '0, second: '0, weight: '0, status: ST_DONE,
                             is_end: 1'b0, has_pre: 1'b0};
        if (accept)
        begin
            if (stream_end)
            begin
                push              = 1'b1;
                push_entry.is_end = 1'b1;
                if (!err_reg)
                begin
                    case (phase_reg)
                        PH_LINE:
                        begin
                            push_entry.has_pre = !any_edge_reg;
                            push_entry.status  = ST_NO_EDGES;
                        end
                        PH_FIRST, PH_SECOND:
                        begin
                            push_entry.has_pre = 1'b1;
                            push_entry.status  = node_oor ? ST_RANGE : ST_TAB;
                        end
                        PH_WEIGHT:
                        begin
                            push_entry.has_pre = 1'b1;
                            if (weight_oor)
                            begin
                                push_entry.status = ST_RANGE;
                            end
                            else
                            begin
                                push_entry.status = ST_EDGE;
                                push_entry.first  = held_first_reg;
                                push_entry.second = held_second_reg;
                                push_entry.weight = acc_reg[7:0];
                            end
                        end
                        default:
                        begin
                            push_entry.has_pre = 1'b1;
                            push_entry.status  = ST_DIGIT;
                        end
                    endcase
                end
                acc_next         = '0;
                tally_next       = '0;
                held_first_next  = '0;
                held_second_next = '0;
                any_edge_next    = 1'b0;
                err_next         = 1'b0;
            end
            else if (!err_reg)
            begin
                case (phase_reg)
                    PH_LINE, PH_TAB1, PH_TAB2:
                    begin
                        if (is_digit)
                        begin
                            acc_next   = {{(ACC_W-4){1'b0}}, digit_val};
                            tally_next = 4'd1;
                        end
                        else if (!(phase_reg == PH_LINE && is_eol))
                        begin
                            push              = 1'b1;
                            push_entry.status = ST_DIGIT;
                            err_next          = 1'b1;
                        end
                    end
                    PH_FIRST, PH_SECOND:
                    begin
                        if (is_digit)
                        begin
                            if (tally_reg < MAX_DIGITS)
                            begin
                                acc_next = acc_x10;
                            end
                            if (tally_reg < TALLY_SAT)
                            begin
                                tally_next = tally_reg + 4'd1;
                            end
                        end
                        else if (node_oor)
                        begin
                            push              = 1'b1;
                            push_entry.status = ST_RANGE;
                            err_next          = 1'b1;
                        end
                        else if (is_tab)
                        begin
                            if (phase_reg == PH_FIRST)
                            begin
                                held_first_next = acc_reg[31:0];
                            end
                            else
                            begin
                                held_second_next = acc_reg[31:0];
                            end
                        end
                        else
                        begin
                            push              = 1'b1;
                            push_entry.status = ST_TAB;
                            err_next          = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (is_digit)
                        begin
                            if (tally_reg < MAX_DIGITS)
                            begin
                                acc_next = acc_x10;
                            end
                            if (tally_reg < TALLY_SAT)
                            begin
                                tally_next = tally_reg + 4'd1;
                            end
                        end
                        else if (weight_oor)
                        begin
                            push              = 1'b1;
                            push_entry.status = ST_RANGE;
                            err_next          = 1'b1;
                        end
                        else if (is_eol)
                        begin
                            push              = 1'b1;
                            push_entry.status = ST_EDGE;
                            push_entry.first  = held_first_reg;
                            push_entry.second = held_second_reg;
                            push_entry.weight = acc_reg[7:0];
                            any_edge_next     = 1'b1;
                        end
                        else
                        begin
                            push              = 1'b1;
                            push_entry.status = ST_TRAIL;
                            err_next          = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LINE;
            acc_reg         <= '0;
            tally_reg       <= '0;
            held_first_reg  <= '0;
            held_second_reg <= '0;
            any_edge_reg    <= 1'b0;
            err_reg         <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            tally_reg       <= tally_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            any_edge_reg    <= any_edge_next;
            err_reg         <= err_next;
        end
    end

endmodule

### rtl/etp_queue.sv
// ----------------------------------------------------------------------------
// Edge-list TSV parser record queue
// Short first-in first-out queue between the front end and the emitter.
// ----------------------------------------------------------------------------
module etp_queue
#(
    parameter int DEPTH = etp_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  etp_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output etp_pkg::entry_t head_entry
);
    import etp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/etp_back.sv
// ----------------------------------------------------------------------------
// Edge-list TSV parser emitter
// Expands queued records into result beats held in an output register;
// an end record with a pending result gives two beats.
// ----------------------------------------------------------------------------
`include "edge_list_tsv_parser_macros.svh"

module etp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  etp_pkg::entry_t head_entry,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     first_node,
    output logic [31:0]     second_node,
    output logic [7:0]      edge_weight,
    output logic [2:0]      status,
    output logic            last_of_run
);
    import etp_pkg::*;

    logic           valid_reg, valid_next;
    logic           pending_reg, pending_next;
    logic [31:0]    first_reg, first_next;
    logic [31:0]    second_reg, second_next;
    logic [7:0]     weight_reg, weight_next;
    status_t        status_reg, status_next;
    logic           last_reg, last_next;
    logic           advance;

    assign advance = !valid_reg || !out_stall;
    assign pop     = advance && !pending_reg && head_valid;

    always_comb
    begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        weight_next  = weight_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        if (advance)
        begin
            if (pending_reg)
            begin
                valid_next   = 1'b1;
                pending_next = 1'b0;
                first_next   = '0;
                second_next  = '0;
                weight_next  = '0;
                status_next  = ST_DONE;
                last_next    = 1'b1;
            end
            else if (head_valid)
            begin
                valid_next = 1'b1;
                if (head_entry.is_end && !head_entry.has_pre)
                begin
                    first_next  = '0;
                    second_next = '0;
                    weight_next = '0;
                    status_next = ST_DONE;
                    last_next   = 1'b1;
                end
                else
                begin
                    first_next   = head_entry.first;
                    second_next  = head_entry.second;
                    weight_next  = head_entry.weight;
                    status_next  = head_entry.status;
                    last_next    = !head_entry.is_end;
                    pending_next = head_entry.is_end;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        weight_reg <= weight_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    assign out_valid   = valid_reg;
    assign first_node  = first_reg;
    assign second_node = second_reg;
    assign edge_weight = weight_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

    `ETP_ASSERT_IMPL(a_pending_has_beat, clk, rst_n, pending_reg, valid_reg, "pending done beat without a held beat")
    `ETP_ASSERT_NEXT(a_done_follows, clk, rst_n, valid_reg && !out_stall && pending_reg, valid_reg && (status_reg == ST_DONE) && last_reg, "done beat did not follow end result")
    `ETP_ASSERT_IMPL(a_not_last_pending, clk, rst_n, valid_reg && !last_reg, pending_reg, "non-final beat without a pending done beat")

endmodule

### rtl/edge_list_tsv_parser.sv
// ----------------------------------------------------------------------------
// Edge-list TSV parser
// Parses tab-separated edge lines from a byte stream into edge records.
//
//   channel   direction   payload
//   in        input       data_byte, stream_end
//   out       output      first_node, second_node, edge_weight, status,
//                         last_of_run
//
// One byte per cycle while in_stall is low; a record passes through the record
// queue and the output register. An end item gives one or two beats.
// Reset returns the line phase to line start and empties the queue.
// in_stall rises only when the record queue is full; out_stall holds the
// output register and the front end runs on until the queue fills.
// ----------------------------------------------------------------------------
module edge_list_tsv_parser
#(
    parameter int QUEUE_DEPTH = etp_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] first_node,
    output logic [31:0] second_node,
    output logic [7:0]  edge_weight,
    output logic [2:0]  status,
    output logic        last_of_run
);
    import etp_pkg::*;

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   q_full;
    logic   head_valid;
    entry_t head_entry;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    etp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .push       (push),
        .push_entry (push_entry)
    );

    etp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    etp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_node  (first_node),
        .second_node (second_node),
        .edge_weight (edge_weight),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

### dv/edge_list_tsv_parser_checker.sv
// ----------------------------------------------------------------------------
// Edge-list TSV parser record checker
// Watches both channels of the parser. Each byte beat is run through a local
// line parser that forms the expected edge, error and done records. Each
// output beat is compared field by field with the oldest expected record.
// The failure count and a few progress counts go back to the testbench top.
// ----------------------------------------------------------------------------
module edge_list_tsv_parser_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] first_node,
    input  logic [31:0] second_node,
    input  logic [7:0]  edge_weight,
    input  logic [2:0]  status,
    input  logic        last_of_run,
    output int          pending,
    output int          mismatches,
    output int          parsed_items,
    output int          edges_seen,
    output int          errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import etp_pkg::*;

    localparam logic [33:0] NODE_MAX   = 34'h0_FFFF_FFFF;
    localparam logic [33:0] WEIGHT_MAX = 34'h0_0000_00FF;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic [7:0]  weight;
        status_t     st;
        logic        last;
    } edge_rec_t;

    edge_rec_t   expected_records[$];

    phase_t      phase;
    logic [33:0] acc;
    logic [3:0]  tally;
    logic [31:0] held_a;
    logic [31:0] held_b;
    logic        seen_edge;
    logic        err_latched;

    int          fail_total;
    int          item_total;
    int          edge_total;
    int          error_total;

    function automatic void clear_state();
        phase       = PH_LINE;
        acc         = '0;
        tally       = '0;
        held_a      = '0;
        held_b      = '0;
        seen_edge   = 1'b0;
        err_latched = 1'b0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic bit is_eol(logic [7:0] c);
        return c == CHAR_LF || c == CHAR_CR;
    endfunction

    function automatic bit too_big(logic [33:0] limit);
        return tally > MAX_DIGITS || acc > limit;
    endfunction

    function automatic void begin_number(logic [7:0] c);
        acc   = 34'(c - CHAR_ZERO);
        tally = 4'd1;
    endfunction

    function automatic void extend_number(logic [7:0] c);
        if (tally < MAX_DIGITS)
            acc = acc * 34'd10 + 34'(c - CHAR_ZERO);
        if (tally < TALLY_SAT)
            tally = tally + 4'd1;
    endfunction

    function automatic void push_record(logic [31:0] a, logic [31:0] b, logic [7:0] w,
                                        status_t st);
        edge_rec_t r;
        r.first  = a;
        r.second = b;
        r.weight = w;
        r.st     = st;
        r.last   = 1'b0;
        expected_records.insert(expected_records.size(), r);
        if (st == ST_EDGE)
            edge_total++;
        else if (st != ST_DONE)
            error_total++;
    endfunction

    function automatic void raise_error(status_t st);
        err_latched = 1'b1;
        push_record('0, '0, '0, st);
    endfunction

    function automatic void parse_beat(logic [7:0] c, logic fin);
        int        before_n;
        before_n = expected_records.size();
        item_total++;
        if (fin)
        begin
            if (!err_latched)
            begin
                case (phase)
                    PH_LINE:
                    begin
                        if (!seen_edge)
                            raise_error(ST_NO_EDGES);
                    end
                    PH_FIRST, PH_SECOND:
                    begin
                        if (too_big(NODE_MAX))
                            raise_error(ST_RANGE);
                        else
                            raise_error(ST_TAB);
                    end
                    PH_WEIGHT:
                    begin
                        if (too_big(WEIGHT_MAX))
                            raise_error(ST_RANGE);
                        else
                            push_record(held_a, held_b, acc[7:0], ST_EDGE);
                    end
                    default:
                        raise_error(ST_DIGIT);
                endcase
            end
            push_record('0, '0, '0, ST_DONE);
            clear_state();
        end
        else if (!err_latched)
        begin
            case (phase)
                PH_LINE:
                begin
                    if (is_digit(c))
                    begin
                        begin_number(c);
                        phase = PH_FIRST;
                    end
                    else if (!is_eol(c))
                        raise_error(ST_DIGIT);
                end
                PH_FIRST, PH_SECOND:
                begin
                    if (is_digit(c))
                        extend_number(c);
                    else if (too_big(NODE_MAX))
                        raise_error(ST_RANGE);
                    else if (c == CHAR_TAB)
                    begin
                        if (phase == PH_FIRST)
                        begin
                            held_a = acc[31:0];
                            phase  = PH_TAB1;
                        end
                        else
                        begin
                            held_b = acc[31:0];
                            phase  = PH_TAB2;
                        end
                    end
                    else
                        raise_error(ST_TAB);
                end
                PH_TAB1, PH_TAB2:
                begin
                    if (is_digit(c))
                    begin
                        begin_number(c);
                        phase = (phase == PH_TAB1) ? PH_SECOND : PH_WEIGHT;
                    end
                    else
                        raise_error(ST_DIGIT);
                end
                default:
                begin
                    if (is_digit(c))
                        extend_number(c);
                    else if (too_big(WEIGHT_MAX))
                        raise_error(ST_RANGE);
                    else if (is_eol(c))
                    begin
                        push_record(held_a, held_b, acc[7:0], ST_EDGE);
                        seen_edge = 1'b1;
                        phase     = PH_LINE;
                    end
                    else
                        raise_error(ST_TRAIL);
                end
            endcase
        end
        if (expected_records.size() > before_n)
            expected_records[expected_records.size() - 1].last = 1'b1;
    endfunction

    function automatic void log_failure(string what, edge_rec_t want, edge_rec_t got);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t %s: expected %0d %0d %0d st %0d last %0b, got %0d %0d %0d st %0d last %0b",
                     $time, what, want.first, want.second, want.weight, want.st, want.last,
                     got.first, got.second, got.weight, got.st, got.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        edge_rec_t got;
        edge_rec_t want;
        if (!rst_n)
            clear_state();
        else
        begin
            if (in_valid && !in_stall)
                parse_beat(data_byte, stream_end);
            if (out_valid && !out_stall)
            begin
                got = {first_node, second_node, edge_weight, status, last_of_run};
                if (expected_records.size() == 0)
                    log_failure("unexpected beat", '0, got);
                else
                begin
                    want = expected_records.pop_front();
                    if (got.first != want.first || got.second != want.second
                        || got.weight != want.weight || got.st != want.st
                        || got.last != want.last)
                        log_failure("record mismatch", want, got);
                end
            end
        end
        pending      <= expected_records.size();
        mismatches   <= fail_total;
        parsed_items <= item_total;
        edges_seen   <= edge_total;
        errors_seen  <= error_total;
    end

endmodule

### dv/tb_edge_list_tsv_parser.sv
// ----------------------------------------------------------------------------
// Edge-list TSV parser testbench
// Sends text streams of tab-separated edge lines, one byte per beat and a
// closing end beat, with random gaps on the input and random stalls on the
// output. A short directed set comes first, then random streams that are
// mostly well formed, with range, separator, trailing and noise faults mixed
// in. The checker beside the parser compares every record.
// ----------------------------------------------------------------------------
module tb_edge_list_tsv_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import etp_pkg::*;

    localparam int ITEM_TARGET    = 1550;
    localparam int QUIET_LIMIT    = 1000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES    = 20;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte  = '0;
    logic        stream_end = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [31:0] first_node;
    logic [31:0] second_node;
    logic [7:0]  edge_weight;
    logic [2:0]  status;
    logic        last_of_run;

    int          pending;
    int          mismatches;
    int          parsed_items;
    int          edges_seen;
    int          errors_seen;

    logic [7:0]  text[$];
    int          stream_count = 0;
    int          quiet_cycles = 0;
    bit          tx_steady    = 1'b0;
    bit          rx_hold_req  = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    edge_list_tsv_parser uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .stream_end  (stream_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_node  (first_node),
        .second_node (second_node),
        .edge_weight (edge_weight),
        .status      (status),
        .last_of_run (last_of_run)
    );

    edge_list_tsv_parser_checker record_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .stream_end   (stream_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .first_node   (first_node),
        .second_node  (second_node),
        .edge_weight  (edge_weight),
        .status       (status),
        .last_of_run  (last_of_run),
        .pending      (pending),
        .mismatches   (mismatches),
        .parsed_items (parsed_items),
        .edges_seen   (edges_seen),
        .errors_seen  (errors_seen)
    );

    function automatic void add_byte(logic [7:0] value);
        text.insert(text.size(), value);
    endfunction

    function automatic void put_number(longint unsigned value, int zeros);
        logic [7:0]      digits[$];
        longint unsigned v;
        v = value;
        do
        begin
            digits.push_front(8'(CHAR_ZERO + v % 10));
            v = v / 10;
        end
        while (v != 0);
        repeat (zeros) digits.push_front(CHAR_ZERO);
        foreach (digits[i])
            add_byte(digits[i]);
    endfunction

    function automatic void put_digits(int count);
        repeat (count) add_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
    endfunction

    function automatic void put_node(bit wild);
        if (!wild)
        begin
            case ($urandom_range(0, 5))
                0:       put_number(64'hFFFF_FFFF, 0);
                1:       put_number(0, $urandom_range(0, 1));
                2, 3:    put_number($urandom, 0);
                default: put_number($urandom_range(0, 999), $urandom_range(0, 2));
            endcase
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       put_number(64'h1_0000_0000 + $urandom_range(0, 9), 0);
                1:       put_number(64'd9999999999, 0);
                2:       put_digits($urandom_range(11, 13));
                3:       put_number($urandom, $urandom_range(1, 2));
                4:       put_number(64'h1_0000_0000 * $urandom_range(0, 1) + $urandom, 0);
                default: ;
            endcase
        end
    endfunction

    function automatic void put_weight(bit wild);
        if (!wild)
        begin
            case ($urandom_range(0, 3))
                0:       put_number(255, 0);
                1:       put_number(0, 0);
                2:       put_number($urandom_range(0, 255), $urandom_range(0, 2));
                default: put_number($urandom_range(0, 255), 0);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       put_number(256, 0);
                1:       put_number($urandom_range(257, 999), 0);
                2:       put_digits($urandom_range(11, 12));
                3:       put_number(255, 8);
                4:       put_number(7, 9);
                default: ;
            endcase
        end
    endfunction

    function automatic void put_sep(bit wild);
        case (wild ? $urandom_range(0, 4) : 0)
            0, 1:    add_byte(CHAR_TAB);
            2:       add_byte(" ");
            3:
            begin
                add_byte(CHAR_TAB);
                add_byte(CHAR_TAB);
            end
            default: add_byte(8'($urandom));
        endcase
    endfunction

    function automatic void put_eol(bit wild);
        case ($urandom_range(0, wild ? 5 : 3))
            0:       add_byte(CHAR_LF);
            1:
            begin
                add_byte(CHAR_CR);
                add_byte(CHAR_LF);
            end
            2:       add_byte(CHAR_CR);
            3:
            begin
                add_byte(CHAR_LF);
                add_byte(CHAR_LF);
            end
            4:
            begin
                add_byte(" ");
                add_byte(CHAR_LF);
            end
            default:
            begin
                add_byte(8'($urandom));
                add_byte(CHAR_LF);
            end
        endcase
    endfunction

    function automatic void put_line(bit wild);
        if (wild && $urandom_range(0, 5) == 0)
            add_byte(8'($urandom));
        put_node(wild);
        put_sep(wild);
        put_node(wild);
        put_sep(wild);
        put_weight(wild);
        put_eol(wild);
    endfunction

    function automatic void build_stream();
        int lines;
        lines = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0)
            add_byte(CHAR_LF);
        repeat (lines) put_line($urandom_range(0, 5) == 0);
        if (text.size() > 4 && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) void'(text.pop_back());
        if (text.size() > 0 && $urandom_range(0, 9) == 0)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
    endfunction

    task automatic send_beat(input logic [7:0] value, input logic fin);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        stream_end <= fin;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_stream();
        foreach (text[i])
            send_beat(text[i], 1'b0);
        send_beat(8'($urandom), 1'b1);
        text.delete();
        stream_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin : receiver
        int gap;
        int run_left;
        bit rx_steady;
        run_left  = 0;
        rx_steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            if (run_left == 0)
            begin
                rx_steady = ($urandom_range(0, 3) == 0);
                run_left  = $urandom_range(8, 40);
            end
            run_left--;
            gap = rx_steady ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("No beat for %0d cycles with %0d records outstanding",
                     quiet_cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_number(64'hFFFF_FFFF, 0);
        add_byte(CHAR_TAB);
        put_number(0, 0);
        add_byte(CHAR_TAB);
        put_number(255, 0);
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
        send_stream();
        send_stream();
        add_byte("x");
        add_byte("1");
        send_stream();
        add_byte("7");
        send_stream();

        while (parsed_items < ITEM_TARGET)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if (stream_count == 10)
            begin
                tx_steady   = 1'b1;
                rx_hold_req = 1'b1;
                repeat (16)
                begin
                    put_number($urandom_range(0, 9), 0);
                    add_byte(CHAR_TAB);
                    put_number($urandom_range(0, 9), 0);
                    add_byte(CHAR_TAB);
                    put_number($urandom_range(0, 9), 0);
                    add_byte(CHAR_LF);
                end
            end
            else
            begin
                if (stream_count % 15 == 0)
                    drain();
                build_stream();
            end
            send_stream();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Parsed %0d byte and end beats over %0d streams", parsed_items, stream_count);
        $display("Compared %0d edge records and %0d error reports", edges_seen, errors_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### edge_list_tsv_parser.f
+incdir+rtl
rtl/etp_pkg.sv
rtl/etp_front.sv
rtl/etp_queue.sv
rtl/etp_back.sv
rtl/edge_list_tsv_parser.sv
dv/edge_list_tsv_parser_checker.sv
dv/tb_edge_list_tsv_parser.sv
